// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl, included by gif_lzw_decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/glzw_pkg.sv =====
`timescale 1ns / 1ps
package glzw_pkg;
  localparam int TABLE_SIZE_DEF    = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int FIFO_DEPTH_DEF    = 16;

  localparam int CODE_W = 12;
  localparam int NFC_W  = 13;
  localparam int CW_W   = 4;
  localparam int MCS_W  = 4;

  localparam logic [MCS_W-1:0] MCS_RESET = 4'd8;
  localparam logic [MCS_W-1:0] MCS_MIN   = 4'd2;
  localparam logic [MCS_W-1:0] MCS_MAX   = 4'd8;

  localparam logic [1:0] MODE_PUSH    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_STARVED  = 3'd1;
  localparam logic [2:0] ST_PAD      = 3'd2;
  localparam logic [2:0] ST_ACCEPT   = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;
  localparam logic [2:0] ST_RESTART  = 3'd5;

  typedef struct packed {
    logic push;
    logic flush;
    logic take;
  } bq_ctl_t;
endpackage

// ===== sv/gif_lzw_decoder.sv =====
`timescale 1ns / 1ps
// gif lzw decoder, pull form. s_tuser carries the request kind: push one
// compressed byte (s_tlast marks the final byte), read one decoded byte, or
// restart the stream. every request gives exactly one result on m_*. a read
// served from the expansion stack passes through S_POP; a read that fetches a
// code waits in S_TAKE while the bit queue gathers it from each source byte it
// spans (one to three), then walks the chain through S_WALK and S_WDATA, since
// the prefix/suffix memories are read once per step of the chain.
// codes are lsb first, 3 to 12 bits wide, growing as the table fills.
// min_code_size must be written on the cfg channel only while idle; the block
// itself does not enforce it. min_code_size is clamped to 2..8. table contents
// survive restart. no clearing pass.
module gif_lzw_decoder import glzw_pkg::*; #(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // data_byte
  input  logic             s_tlast,   // end_of_data
  input  logic [1:0]       s_tuser,   // mode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic [3:0]       m_tuser,   // status [2:0], bad_data [3]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MCS_W-1:0] cfg_data   // min_code_size
);
`include "assert_macros.svh"

  localparam int TAW = $clog2(TABLE_SIZE);
  localparam int SCW = $clog2(TABLE_SIZE + 1);
  localparam int QW  = $clog2(8 * FIFO_DEPTH + 1);
  localparam logic [QW-1:0] PUSH_MAX = QW'(8 * FIFO_DEPTH - 8);

  typedef enum logic [2:0] {S_IDLE, S_POP, S_TAKE, S_WALK, S_WDATA} state_t;

  state_t            st;
  logic [MCS_W-1:0]  mcs, eff;
  logic [NFC_W-1:0]  clear13, clear_p1, limit_init, nfc_init;
  logic [CW_W-1:0]   cw, cw_init;
  logic [NFC_W-1:0]  limit, nfc, nfc_p1;
  logic [CODE_W-1:0] prev, incode, wcode;
  logic [7:0]        first;
  logic              af, ended, bad;
  logic [SCW-1:0]    sc, sc_m1;

  // bit queue
  bq_ctl_t           bq_ctl;
  logic [QW-1:0]     bq_bits;
  logic              bq_done;
  logic [CODE_W-1:0] bq_code;
  logic [CW_W-1:0]   take_n;

  // memories
  logic              stk_we, dict_we;
  logic [7:0]        stk_wdata, stk_rdata, suf_rdata;
  logic [CODE_W-1:0] pre_rdata;
  logic [TAW-1:0]    widx;

  // decisions
  logic acc, push_ok, short_now, short_after_clear;
  logic [NFC_W-1:0] code13, wcode13;
  logic is_clear, is_end, walk_go, stack_room;

  glzw_bitq #(.FIFO_DEPTH(FIFO_DEPTH), .QW(QW)) u_bitq (
    .clk(clk), .rst(rst), .ctl(bq_ctl), .push_byte(s_tdata), .take_n(take_n),
    .bits(bq_bits), .done(bq_done), .code(bq_code)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sc[TAW-1:0]), .wdata(stk_wdata),
    .raddr(sc_m1[TAW-1:0]), .rdata(stk_rdata)
  );

  glzw_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_SIZE)) u_prefix (
    .clk(clk), .we(dict_we), .waddr(nfc[TAW-1:0]), .wdata(prev),
    .raddr(widx), .rdata(pre_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_suffix (
    .clk(clk), .we(dict_we), .waddr(nfc[TAW-1:0]), .wdata(wcode[7:0]),
    .raddr(widx), .rdata(suf_rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (st == S_IDLE) && !m_tvalid;

  always_comb begin
    // clamp the configured code size
    if (mcs < MCS_MIN) eff = MCS_MIN;
    else if (mcs > MCS_MAX) eff = MCS_MAX;
    else eff = mcs;
    clear13    = NFC_W'(1) << eff;
    clear_p1   = clear13 + NFC_W'(1);
    limit_init = clear13 << 1;
    nfc_init   = clear13 + NFC_W'(2);
    cw_init    = eff + CW_W'(1);
    nfc_p1     = nfc + NFC_W'(1);
    sc_m1      = sc - SCW'(1);

    acc        = s_tvalid && s_tready;
    push_ok    = !ended && (bq_bits <= PUSH_MAX);
    short_now  = bq_bits < QW'(cw);
    short_after_clear = bq_bits < QW'(cw_init);

    code13     = NFC_W'(bq_code);
    wcode13    = NFC_W'(wcode);
    is_clear   = (code13 == clear13);
    is_end     = (code13 == clear_p1);
    stack_room = sc < SCW'(TABLE_SIZE);
    walk_go    = (wcode13 >= clear13) && stack_room;
    // a chain code at or beyond the table size folds to entry zero
    widx       = (wcode13 >= NFC_W'(TABLE_SIZE)) ? '0 : wcode[TAW-1:0];

    take_n     = cw;
    bq_ctl     = '0;
    stk_we     = 1'b0;
    stk_wdata  = suf_rdata;
    dict_we    = 1'b0;

    unique case (st)
      S_IDLE: begin
        if (acc) begin
          if (s_tuser == MODE_PUSH) begin
            bq_ctl.push = push_ok;
          end else if (s_tuser == MODE_READ) begin
            if (sc == '0) begin
              bq_ctl.take  = !short_now;
              bq_ctl.flush = short_now && ended;
            end
          end else if (s_tuser == MODE_RESTART) begin
            bq_ctl.flush = 1'b1;
          end
        end
      end
      S_TAKE: begin
        if (bq_done) begin
          if (is_clear) begin
            take_n       = cw_init;
            bq_ctl.take  = !short_after_clear;
            bq_ctl.flush = short_after_clear && ended;
          end else if (is_end) begin
            bq_ctl.flush = 1'b1;
          end else if (!af && (code13 >= nfc)) begin
            // unknown code: lead with the previous first byte
            stk_we    = stack_room;
            stk_wdata = first;
          end
        end
      end
      S_WALK: begin
        dict_we = !walk_go && (nfc < NFC_W'(TABLE_SIZE));
      end
      S_WDATA: begin
        stk_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      mcs      <= MCS_RESET;
      cw       <= CW_W'(MCS_RESET) + CW_W'(1);
      limit    <= NFC_W'(2) << MCS_RESET;
      nfc      <= (NFC_W'(1) << MCS_RESET) + NFC_W'(2);
      prev     <= '0;
      first    <= '0;
      af       <= 1'b1;
      ended    <= 1'b0;
      sc       <= '0;
      bad      <= 1'b0;
      incode   <= '0;
      wcode    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mcs <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (acc) begin
            m_tdata <= '0;
            if (s_tuser == MODE_PUSH) begin
              m_tvalid <= 1'b1;
              if (push_ok) begin
                ended   <= ended | s_tlast;
                m_tuser <= {1'b0, ST_ACCEPT};
              end else begin
                m_tuser <= {1'b0, ST_REJECT};
              end
            end else if (s_tuser == MODE_READ) begin
              if (sc != '0) begin
                sc <= sc_m1;
                st <= S_POP;
              end else if (short_now) begin
                m_tvalid <= 1'b1;
                m_tuser  <= {1'b0, ended ? ST_PAD : ST_STARVED};
              end else begin
                st <= S_TAKE;
              end
            end else if (s_tuser == MODE_RESTART) begin
              cw       <= cw_init;
              limit    <= limit_init;
              nfc      <= nfc_init;
              sc       <= '0;
              af       <= 1'b1;
              ended    <= 1'b0;
              m_tvalid <= 1'b1;
              m_tuser  <= {1'b0, ST_RESTART};
            end else begin
              m_tvalid <= 1'b1;
              m_tuser  <= {1'b0, ST_STARVED};
            end
          end
        end
        S_POP: begin
          m_tvalid <= 1'b1;
          m_tdata  <= stk_rdata;
          m_tuser  <= {1'b0, ST_BYTE};
          st       <= S_IDLE;
        end
        S_TAKE: begin
          if (bq_done) begin
            if (is_clear) begin
              // dictionary reset, next code is a raw byte
              cw    <= cw_init;
              limit <= limit_init;
              nfc   <= nfc_init;
              sc    <= '0;
              af    <= 1'b1;
              if (short_after_clear) begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tuser  <= {1'b0, ended ? ST_PAD : ST_STARVED};
                st       <= S_IDLE;
              end
            end else if (is_end) begin
              ended    <= 1'b1;
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tuser  <= {1'b0, ST_PAD};
              st       <= S_IDLE;
            end else if (af) begin
              // first code after clear must be a literal
              af       <= 1'b0;
              m_tvalid <= 1'b1;
              m_tuser  <= {code13 > clear13, ST_BYTE};
              if (code13 > clear13) begin
                first   <= '0;
                prev    <= '0;
                m_tdata <= '0;
              end else begin
                first   <= bq_code[7:0];
                prev    <= bq_code;
                m_tdata <= bq_code[7:0];
              end
              st <= S_IDLE;
            end else begin
              if (code13 >= nfc) begin
                bad    <= (code13 > nfc);
                incode <= (code13 > nfc) ? '0 : bq_code;
                wcode  <= prev;
                if (stack_room) sc <= sc + SCW'(1);
              end else begin
                bad    <= 1'b0;
                incode <= bq_code;
                wcode  <= bq_code;
              end
              st <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (walk_go) begin
            st <= S_WDATA;
          end else begin
            // chain reached a root byte or the stack is full: add entry (while the table has room) and deliver
            first <= wcode[7:0];
            if (nfc < NFC_W'(TABLE_SIZE)) begin
              nfc <= nfc_p1;
              if ((nfc_p1 >= limit) && (cw < CW_W'(MAX_CODE_BITS))) begin
                cw    <= cw + CW_W'(1);
                limit <= limit << 1;
              end
            end
            prev     <= incode;
            m_tvalid <= 1'b1;
            m_tdata  <= wcode[7:0];
            m_tuser  <= {bad, ST_BYTE};
            st       <= S_IDLE;
          end
        end
        S_WDATA: begin
          sc    <= sc + SCW'(1);
          wcode <= pre_rdata;
          st    <= S_WALK;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_ready_out_free, clk, rst, s_tready, !m_tvalid, "ready while result pending")
  `ASSERT_ALWAYS(a_stack_bound, clk, rst, sc <= SCW'(TABLE_SIZE), "stack count overflow")
  `ASSERT_ALWAYS(a_fifo_bound, clk, rst, bq_bits <= QW'(8 * FIFO_DEPTH), "bit queue overflow")
  `ASSERT_ALWAYS(a_width_bound, clk, rst, (cw >= CW_W'(3)) && (cw <= CW_W'(MAX_CODE_BITS)),
    "code width out of range")
endmodule

// ===== sv/glzw_ram.sv =====
`timescale 1ns / 1ps
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/glzw_bitq.sv =====
`timescale 1ns / 1ps
module glzw_bitq import glzw_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int QW = $clog2(8 * FIFO_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  bq_ctl_t           ctl,
  input  logic [7:0]        push_byte,
  input  logic [CW_W-1:0]   take_n,
  output logic [QW-1:0]     bits,
  output logic              done,
  output logic [CODE_W-1:0] code
);
  // one spare byte slot covers a partly consumed head byte
  localparam int QD  = FIFO_DEPTH + 1;
  localparam int QAW = $clog2(QD);

  typedef enum logic [1:0] {B_IDLE, B_ADDR, B_DATA, B_DONE} bstate_t;

  bstate_t          st;
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [2:0]       off;
  logic [CW_W-1:0]  remain, shift;
  logic [7:0]       rdata, shifted, mask, piece;
  logic [CW_W-1:0]  avail, t;
  logic [CW_W-1:0]  off_sum;

  function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
    return (p == QAW'(QD - 1)) ? '0 : p + 1'b1;
  endfunction

  glzw_ram #(.WIDTH(8), .DEPTH(QD)) u_q (
    .clk(clk), .we(ctl.push), .waddr(wr_ptr), .wdata(push_byte),
    .raddr(rd_ptr), .rdata(rdata)
  );

  always_comb begin
    avail   = CW_W'(8) - {1'b0, off};
    t       = (avail < remain) ? avail : remain;
    shifted = rdata >> off;
    mask    = (8'd1 << t) - 8'd1;
    piece   = shifted & mask;
    off_sum = {1'b0, off} + t;
  end

  assign done = (st == B_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= B_IDLE;
      wr_ptr <= '0;
      rd_ptr <= '0;
      off    <= '0;
      bits   <= '0;
      remain <= '0;
      shift  <= '0;
      code   <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= bump(wr_ptr);
        bits   <= bits + QW'(8);
      end
      if (ctl.flush) begin
        rd_ptr <= wr_ptr;
        off    <= '0;
        bits   <= '0;
      end
      unique case (st)
        B_IDLE, B_DONE: begin
          st <= B_IDLE;
          if (ctl.take) begin
            remain <= take_n;
            shift  <= '0;
            code   <= '0;
            st     <= B_ADDR;
          end
        end
        B_ADDR: st <= B_DATA;
        B_DATA: begin
          code   <= code | (CODE_W'(piece) << shift);
          shift  <= shift + t;
          remain <= remain - t;
          bits   <= bits - QW'(t);
          if (off_sum[3]) begin
            off    <= '0;
            rd_ptr <= bump(rd_ptr);
          end else begin
            off <= off_sum[2:0];
          end
          st <= (remain == t) ? B_DONE : B_ADDR;
        end
        default: st <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/gif_lzw_checker.sv =====
`timescale 1ns / 1ps
module gif_lzw_checker import glzw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [7:0]       m_tdata,
  input  logic [3:0]       m_tuser,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [MCS_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               fifo_level
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       bad_data;
  } decoded_t;

  decoded_t decoded_q[$];

  // decoder image
  logic [11:0]      prefix_mem[TABLE_SIZE_DEF];
  logic [7:0]       suffix_mem[TABLE_SIZE_DEF];
  logic [7:0]       stack_mem[TABLE_SIZE_DEF];
  int unsigned      stack_n;
  bit               bitq[$];
  logic [MCS_W-1:0] mcs;
  int unsigned      width, limit, next_free, prev_code, first_byte;
  bit               awaiting, ended;

  function automatic int unsigned clear_val();
    int unsigned m;
    m = (mcs < MCS_MIN) ? MCS_MIN : (mcs > MCS_MAX) ? MCS_MAX : mcs;
    return 1 << m;
  endfunction

  function automatic void dict_init();
    width     = $clog2(clear_val()) + 1;
    limit     = clear_val() << 1;
    next_free = clear_val() + 2;
    stack_n   = 0;
  endfunction

  function automatic int unsigned take_bits(int unsigned n);
    int unsigned v;
    v = 0;
    for (int i = 0; i < n; i++) v |= int'(bitq.pop_front()) << i;
    return v;
  endfunction

  function automatic void stack_push(int unsigned b);
    if (stack_n < TABLE_SIZE_DEF) begin
      stack_mem[stack_n] = b[7:0];
      stack_n++;
    end
  endfunction

  function automatic logic [2:0] short_bits();
    if (ended) begin
      bitq.delete();
      return ST_PAD;
    end
    return ST_STARVED;
  endfunction

  function automatic logic [2:0] first_code(output int unsigned b, inout bit bad);
    int unsigned code;
    while (1) begin
      if (bitq.size() < width) return short_bits();
      code = take_bits(width);
      if (code == clear_val()) begin
        dict_init();
        continue;
      end
      if (code == clear_val() + 1) begin
        ended = 1;
        bitq.delete();
        return ST_PAD;
      end
      awaiting = 0;
      if (code > clear_val()) begin
        code = 0;
        bad  = 1;
      end
      first_byte = code & 8'hFF;
      prev_code  = code & 12'hFFF;
      b = first_byte;
      return ST_BYTE;
    end
  endfunction

  function automatic logic [2:0] decode_read(output int unsigned b, inout bit bad);
    int unsigned code, incode, nf;
    b = 0;
    if (stack_n > 0) begin
      stack_n--;
      b = stack_mem[stack_n];
      return ST_BYTE;
    end
    if (awaiting) return first_code(b, bad);
    if (bitq.size() < width) return short_bits();
    code = take_bits(width);
    if (code == clear_val()) begin
      dict_init();
      awaiting = 1;
      return first_code(b, bad);
    end
    if (code == clear_val() + 1) begin
      ended = 1;
      bitq.delete();
      return ST_PAD;
    end
    incode = code;
    if (code >= next_free) begin
      if (code > next_free) begin
        bad    = 1;
        incode = 0;
      end
      stack_push(first_byte);
      code = prev_code;
    end
    while (code >= clear_val() && stack_n < TABLE_SIZE_DEF) begin
      stack_push(suffix_mem[code % TABLE_SIZE_DEF]);
      code = prefix_mem[code % TABLE_SIZE_DEF];
    end
    first_byte = code & 8'hFF;
    nf = next_free;
    if (nf < TABLE_SIZE_DEF) begin
      prefix_mem[nf] = prev_code[11:0];
      suffix_mem[nf] = first_byte[7:0];
      next_free = nf + 1;
      if (next_free >= limit && width < MAX_CODE_BITS_DEF) begin
        width++;
        limit <<= 1;
      end
    end
    prev_code = incode & 12'hFFF;
    b = first_byte;
    return ST_BYTE;
  endfunction

  function automatic decoded_t predict(logic [1:0] mode, logic [7:0] d, logic last);
    decoded_t    r;
    int unsigned b;
    bit          bad;
    b   = 0;
    bad = 0;
    r   = '0;
    case (mode)
      MODE_PUSH: begin
        if (ended || bitq.size() + 8 > FIFO_DEPTH_DEF * 8) begin
          r.status = ST_REJECT;
        end else begin
          for (int i = 0; i < 8; i++) bitq.push_back(d[i]);
          if (last) ended = 1;
          r.status = ST_ACCEPT;
        end
      end
      MODE_READ: begin
        r.status = decode_read(b, bad);
        if (r.status == ST_BYTE) begin
          r.out_byte = b[7:0];
          r.bad_data = bad;
        end
      end
      MODE_RESTART: begin
        bitq.delete();
        dict_init();
        awaiting = 1;
        ended    = 0;
        r.status = ST_RESTART;
      end
      default: r.status = ST_STARVED;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    decoded_t e;
    if (rst) begin
      mcs        = MCS_RESET;
      bitq.delete();
      dict_init();
      prev_code  = 0;
      first_byte = 0;
      awaiting   = 1;
      ended      = 0;
      decoded_q.delete();
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $error("result with nothing outstanding: byte %0d status %0d", m_tdata, m_tuser[2:0]);
          fail_count <= fail_count + 1;
        end else begin
          e = decoded_q.pop_front();
          if (m_tdata !== e.out_byte || m_tuser[2:0] !== e.status
              || m_tuser[3] !== e.bad_data) begin
            fail_count <= fail_count + 1;
            if (m_tdata !== e.out_byte)
              $error("out_byte expected %0d actual %0d", e.out_byte, m_tdata);
            if (m_tuser[2:0] !== e.status)
              $error("status expected %0d actual %0d", e.status, m_tuser[2:0]);
            if (m_tuser[3] !== e.bad_data)
              $error("bad_data expected %0d actual %0d", e.bad_data, m_tuser[3]);
          end
        end
      end
      if (cfg_valid && cfg_ready) mcs = cfg_data;
      if (s_tvalid && s_tready) decoded_q.push_back(predict(s_tuser, s_tdata, s_tlast));
    end
    pending    <= decoded_q.size();
    fifo_level <= bitq.size();
  end

endmodule

// ===== dv/tb_gif_lzw_decoder.sv =====
`timescale 1ns / 1ps
module tb_gif_lzw_decoder;
  import glzw_pkg::*;

  // mode value the block does not define, answered as starved
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         ITEM_GOAL   = 1300;
  localparam int         DRAIN_WAIT  = 40;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // data_byte
  logic             s_tlast;   // end_of_data
  logic [1:0]       s_tuser;   // mode
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;   // out_byte
  logic [3:0]       m_tuser;   // status [2:0], bad_data [3]
  logic             cfg_valid;
  logic             cfg_ready;
  logic [MCS_W-1:0] cfg_data;

  int fail_count, pending, fifo_level;
  int cycles = 0;
  int items  = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  // encoder-side mirror of the code width progression
  logic [MCS_W-1:0] enc_mcs = MCS_RESET;
  int unsigned      enc_clear, enc_width, enc_limit, enc_next;
  bit               enc_awaiting;
  logic [7:0]       payload[$];
  logic [31:0]      bit_acc;
  int               acc_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gif_lzw_decoder uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  gif_lzw_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .fifo_level(fifo_level)
  );

  // result side backpressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_gif_lzw_decoder NOT OK");
      $finish;
    end
  end

  // one request; valid stays up for back-to-back requests
  task automatic send(logic [1:0] mode, logic [7:0] d, logic last);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= d;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // new code size, then a restart so the dictionary follows it
  task automatic write_mcs(logic [MCS_W-1:0] v);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    enc_mcs = v;
    send(MODE_RESTART, 8'h00, 1'b0);
  endtask

  // code stream builder, lsb first
  function automatic void enc_init();
    int unsigned m;
    m = (enc_mcs < MCS_MIN) ? MCS_MIN : (enc_mcs > MCS_MAX) ? MCS_MAX : enc_mcs;
    enc_clear = 1 << m;
    enc_width = m + 1;
    enc_limit = enc_clear << 1;
    enc_next  = enc_clear + 2;
  endfunction

  function automatic void put_code(int unsigned code);
    bit_acc |= code << acc_n;
    acc_n   += enc_width;
    while (acc_n >= 8) begin
      payload.push_back(bit_acc[7:0]);
      bit_acc >>= 8;
      acc_n   -= 8;
    end
  endfunction

  function automatic void start_stream();
    payload.delete();
    bit_acc = 0;
    acc_n   = 0;
    enc_init();
    enc_awaiting = 1;
  endfunction

  function automatic void emit_clear();
    put_code(enc_clear);
    enc_init();
    enc_awaiting = 1;
  endfunction

  function automatic void emit_data(int unsigned code);
    put_code(code);
    if (enc_awaiting) begin
      enc_awaiting = 0;
    end else if (enc_next < TABLE_SIZE_DEF) begin
      enc_next++;
      if (enc_next >= enc_limit && enc_width < MAX_CODE_BITS_DEF) begin
        enc_width++;
        enc_limit <<= 1;
      end
    end
  endfunction

  function automatic void end_stream(bit with_end_code);
    if (with_end_code) put_code(enc_clear + 1);
    if (acc_n > 0) payload.push_back(bit_acc[7:0]);
    acc_n = 0;
  endfunction

  // push the payload interleaved with reads, keeping the bit fifo from overflowing
  task automatic play(bit mark_last, int tail_reads);
    int idx;
    idx = 0;
    while (idx < payload.size()) begin
      if (fifo_level <= 104 && $urandom_range(0, 99) < 60) begin
        send(MODE_PUSH, payload[idx], mark_last && idx == payload.size() - 1);
        idx++;
      end else begin
        send(MODE_READ, 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    repeat (tail_reads) send(MODE_READ, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_stream();
    int n, r;
    send(MODE_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
    start_stream();
    if ($urandom_range(0, 9) < 7) emit_clear();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(8, 50);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        emit_clear();
      end else if (r < 6 && enc_awaiting) begin
        // non-literal code right after a clear or stream start
        emit_data($urandom_range(enc_clear + 2, (1 << enc_width) - 1));
      end else if (r < 6 && enc_next + 1 < (1 << enc_width)) begin
        // code beyond the next free entry
        emit_data($urandom_range(enc_next + 1, (1 << enc_width) - 1));
      end else if (enc_awaiting || r < 50) begin
        emit_data($urandom_range(0, enc_clear - 1));
      end else begin
        emit_data($urandom_range(enc_clear + 2, enc_next));
      end
    end
    end_stream($urandom_range(0, 9) < 8);
    play($urandom_range(0, 9) != 0, $urandom_range(2, 20));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 25))
      send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [MCS_W-1:0] settings[7];
    int               goal;
    settings = '{4'd2, 4'd5, 4'd0, 4'd15, 4'd3, 4'd8, 4'd7};

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    s_tuser   <= MODE_PUSH;
    cfg_valid <= 1'b0;
    cfg_data  <= MCS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, undefined mode, then a hand-built stream
    send(MODE_READ, 8'h00, 1'b0);
    send(MODE_UNUSED, 8'hFF, 1'b1);
    send(MODE_RESTART, 8'h00, 1'b0);
    start_stream();
    emit_clear();
    emit_data(0);
    emit_data(255);
    emit_data(enc_next);        // entry being defined right now
    emit_data(enc_next + 5);    // beyond the next free entry
    emit_data(enc_clear + 2);
    emit_clear();
    emit_data(enc_clear + 3);   // non-literal right after a clear
    emit_data(77);
    end_stream(1'b1);
    play(1'b1, 12);             // reads run past the end code
    send(MODE_PUSH, 8'hA5, 1'b0);  // push after end
    // fill the bit fifo until a push bounces
    send(MODE_RESTART, 8'h00, 1'b0);
    wait_drained();
    repeat (FIFO_DEPTH_DEF + 1) send(MODE_PUSH, 8'hFF, 1'b0);
    send(MODE_READ, 8'h00, 1'b0);
    // end code straight after a clear, then short bits with end marked
    send(MODE_RESTART, 8'h00, 1'b0);
    start_stream();
    emit_clear();
    end_stream(1'b1);
    play(1'b0, 2);
    send(MODE_RESTART, 8'h00, 1'b0);
    send(MODE_PUSH, 8'h03, 1'b1);
    send(MODE_READ, 8'h00, 1'b0);
    send(MODE_READ, 8'h00, 1'b0);

    // random phases across settings and idle patterns
    for (int p = 0; p < 7; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      write_mcs(settings[p]);
      goal = ITEM_GOAL * (p + 1) / 7;
      while (items < goal) begin
        if ($urandom_range(0, 99) < 85) random_stream();
        else noise_burst();
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) $display("tb_gif_lzw_decoder OK");
    else $display("tb_gif_lzw_decoder NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/glzw_pkg.sv
sv/glzw_ram.sv
sv/glzw_bitq.sv
sv/gif_lzw_decoder.sv
dv/gif_lzw_checker.sv
dv/tb_gif_lzw_decoder.sv
